// ===== rtl/mcsp_pkg.sv =====
// ============================================================================
// mcsp_pkg - shared types and codes of the software PWM channel block
// Request kinds, queued request word, channel table entry and result codes.
// ============================================================================
`default_nettype none

package mcsp_pkg;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_t;

  localparam logic [1:0] TIMER_SERVED    = 2'd0;
  localparam logic [1:0] TIMER_MAX_VALID = 2'd2;

  localparam logic EV_STATUS = 1'b0;
  localparam logic EV_DRIVE  = 1'b1;

  localparam logic LVL_LOW  = 1'b0;
  localparam logic LVL_HIGH = 1'b1;

  typedef struct packed {
    req_kind_t   kind;
    logic [2:0]  port;
    logic [2:0]  pin;
    logic [1:0]  timer;
    logic [15:0] period;
    logic [15:0] duty;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  port;
    logic [2:0]  pin;
    logic [1:0]  timer;
    logic [15:0] period;
    logic [15:0] duty;
    logic [15:0] count;
    logic        running;
  } chan_entry_t;

endpackage

`default_nettype wire

// ===== rtl/mcsp_in_if.sv =====
// ============================================================================
// mcsp_in_if - request channel
// Valid/ready channel carrying one request word.
// ============================================================================
`default_nettype none

interface mcsp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  port;
  logic [2:0]  pin;
  logic [1:0]  timer_channel;
  logic [15:0] period_ticks;
  logic [15:0] duty_ticks;

  modport source (
    output valid, req_type, port, pin, timer_channel, period_ticks, duty_ticks,
    input  ready
  );

  modport sink (
    input  valid, req_type, port, pin, timer_channel, period_ticks, duty_ticks,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/mcsp_out_if.sv =====
// ============================================================================
// mcsp_out_if - result channel
// Valid/ready channel carrying one status or pin drive word.
// ============================================================================
`default_nettype none

interface mcsp_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [2:0] out_port;
  logic [2:0] out_pin;
  logic       level;
  logic       error;
  logic       last;

  modport source (
    output valid, event_kind, out_port, out_pin, level, error, last,
    input  ready
  );

  modport sink (
    input  valid, event_kind, out_port, out_pin, level, error, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/mcsp_front.sv =====
// ============================================================================
// mcsp_front - request intake
// Accepts request words, drops unused kinds and queues the rest in a
// two-entry queue for the channel sequencer.
// ============================================================================
`default_nettype none

module mcsp_front (
  input  logic                clk,
  input  logic                rst_n,
  mcsp_in_if.sink             in_ch,
  output logic                q_valid,
  output mcsp_pkg::req_item_t q_item,
  input  logic                q_pop
);

  localparam int QDEPTH = 2;

  mcsp_pkg::req_item_t fifo_r [QDEPTH];
  mcsp_pkg::req_item_t in_item;
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push;
  logic                pop;

  always_comb begin
    in_item.kind   = mcsp_pkg::req_kind_t'(in_ch.req_type);
    in_item.port   = in_ch.port;
    in_item.pin    = in_ch.pin;
    in_item.timer  = in_ch.timer_channel;
    in_item.period = in_ch.period_ticks;
    in_item.duty   = in_ch.duty_ticks;
  end

  assign in_ch.ready = (cnt_r != 2'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready && (in_item.kind != mcsp_pkg::REQ_NONE);
  assign pop         = q_pop && (cnt_r != 2'd0);
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mcsp_back.sv =====
// ============================================================================
// mcsp_back - channel sequencer
// Holds the channel table, walks it one entry per cycle for lookups and
// ticks, pausing on a full result register, and drives the result register.
// ============================================================================
`default_nettype none

module mcsp_back #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  mcsp_pkg::req_item_t q_item,
  output logic                q_pop,
  mcsp_out_if.source          out_ch
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_TICK
  } state_t;

  state_t                state_r, state_nxt;
  mcsp_pkg::req_item_t   cur_r, cur_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [2:0]            pend_port_r, pend_port_nxt;
  logic [2:0]            pend_pin_r, pend_pin_nxt;
  logic                  pend_lvl_r, pend_lvl_nxt;
  logic                  out_v_r, out_v_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic [2:0]            out_port_r, out_port_nxt;
  logic [2:0]            out_pin_r, out_pin_nxt;
  logic                  out_lvl_r, out_lvl_nxt;
  logic                  out_err_r, out_err_nxt;
  logic                  out_last_r, out_last_nxt;

  mcsp_pkg::chan_entry_t tbl_r [NUM_CHANNELS];
  mcsp_pkg::chan_entry_t ent;
  mcsp_pkg::chan_entry_t tbl_wdata;
  logic                  tbl_we;

  logic                  out_free;
  logic                  in_range;
  logic                  hit;
  logic                  active;
  logic                  ev;
  logic [15:0]           cnt_inc;

  assign ent      = tbl_r[idx_r[IDX_W-1:0]];
  assign out_free = !out_v_r || out_ch.ready;
  assign in_range = (idx_r < used_r);
  assign hit      = in_range && (ent.port == cur_r.port) && (ent.pin == cur_r.pin);
  assign active   = in_range && ent.running && (ent.timer == mcsp_pkg::TIMER_SERVED);
  assign ev       = active && ((ent.count == 16'd0) || (ent.count == ent.duty));
  assign cnt_inc  = 16'(ent.count + 16'd1);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    pend_v_nxt    = pend_v_r;
    pend_port_nxt = pend_port_r;
    pend_pin_nxt  = pend_pin_r;
    pend_lvl_nxt  = pend_lvl_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_port_nxt  = out_port_r;
    out_pin_nxt   = out_pin_r;
    out_lvl_nxt   = out_lvl_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;
    tbl_we        = 1'b0;
    tbl_wdata     = ent;
    q_pop         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_nxt    = q_item;
          idx_nxt    = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = (q_item.kind == mcsp_pkg::REQ_TICK) ? ST_TICK : ST_FIND;
        end
      end

      ST_FIND: begin
        if (hit || !in_range) begin
          if (out_free) begin
            out_v_nxt    = 1'b1;
            out_kind_nxt = mcsp_pkg::EV_STATUS;
            out_port_nxt = 3'd0;
            out_pin_nxt  = 3'd0;
            out_lvl_nxt  = mcsp_pkg::LVL_LOW;
            out_err_nxt  = 1'b0;
            out_last_nxt = 1'b1;
            state_nxt    = ST_IDLE;
            if (cur_r.kind == mcsp_pkg::REQ_STOP) begin
              if (hit) begin
                tbl_we            = 1'b1;
                tbl_wdata.running = 1'b0;
                out_kind_nxt      = mcsp_pkg::EV_DRIVE;
                out_port_nxt      = cur_r.port;
                out_pin_nxt       = cur_r.pin;
              end else begin
                out_err_nxt = 1'b1;
              end
            end else if (!hit && (used_r == CNT_W'(NUM_CHANNELS))) begin
              out_err_nxt = 1'b1;
            end else begin
              tbl_we            = 1'b1;
              tbl_wdata.port    = cur_r.port;
              tbl_wdata.pin     = cur_r.pin;
              tbl_wdata.timer   = cur_r.timer;
              tbl_wdata.period  = cur_r.period;
              tbl_wdata.duty    = cur_r.duty;
              tbl_wdata.count   = 16'd0;
              tbl_wdata.running = 1'b1;
              if (!hit) begin
                used_nxt    = CNT_W'(used_r + 1'b1);
                out_err_nxt = (cur_r.timer > mcsp_pkg::TIMER_MAX_VALID);
              end
            end
          end
        end else begin
          idx_nxt = CNT_W'(idx_r + 1'b1);
        end
      end

      ST_TICK: begin
        if (!in_range) begin
          if (!pend_v_r) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            out_v_nxt    = 1'b1;
            out_kind_nxt = mcsp_pkg::EV_DRIVE;
            out_port_nxt = pend_port_r;
            out_pin_nxt  = pend_pin_r;
            out_lvl_nxt  = pend_lvl_r;
            out_err_nxt  = 1'b0;
            out_last_nxt = 1'b1;
            pend_v_nxt   = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end else if (!(ev && pend_v_r && !out_free)) begin
          if (ev) begin
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_kind_nxt = mcsp_pkg::EV_DRIVE;
              out_port_nxt = pend_port_r;
              out_pin_nxt  = pend_pin_r;
              out_lvl_nxt  = pend_lvl_r;
              out_err_nxt  = 1'b0;
              out_last_nxt = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_port_nxt = ent.port;
            pend_pin_nxt  = ent.pin;
            pend_lvl_nxt  = (ent.count == 16'd0) ? mcsp_pkg::LVL_HIGH : mcsp_pkg::LVL_LOW;
          end
          if (active) begin
            tbl_we          = 1'b1;
            tbl_wdata.count = (cnt_inc == ent.period) ? 16'd0 : cnt_inc;
          end
          idx_nxt = CNT_W'(idx_r + 1'b1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      used_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    cur_r       <= cur_nxt;
    idx_r       <= idx_nxt;
    pend_port_r <= pend_port_nxt;
    pend_pin_r  <= pend_pin_nxt;
    pend_lvl_r  <= pend_lvl_nxt;
    out_kind_r  <= out_kind_nxt;
    out_port_r  <= out_port_nxt;
    out_pin_r   <= out_pin_nxt;
    out_lvl_r   <= out_lvl_nxt;
    out_err_r   <= out_err_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_r[idx_r[IDX_W-1:0]] <= tbl_wdata;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.event_kind = out_kind_r;
  assign out_ch.out_port   = out_port_r;
  assign out_ch.out_pin    = out_pin_r;
  assign out_ch.level      = out_lvl_r;
  assign out_ch.error      = out_err_r;
  assign out_ch.last       = out_last_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(NUM_CHANNELS))
    else $error("allocated count beyond table size");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (used_r == $past(used_r)) || (used_r == CNT_W'($past(used_r) + 1'b1)))
    else $error("allocated count moved by more than one");

  a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == ST_TICK))
    else $error("held drive event outside a tick walk");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (idx_r <= used_r))
    else $error("walk index past allocated entries");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (idx_r < CNT_W'(NUM_CHANNELS)))
    else $error("table write outside the table");

endmodule

`default_nettype wire

// ===== rtl/multi_channel_software_pwm.sv =====
// ============================================================================
// multi_channel_software_pwm - multi-channel software PWM generator
// Table of PWM channels keyed by port and pin; start, stop and timer tick
// requests in, status words and pin drive words out.
// ============================================================================
//
//   channel | dir | word                                           | handshake
//   --------+-----+------------------------------------------------+----------
//   in_ch   | in  | req_type port pin timer_channel period duty     | valid/ready
//   out_ch  | out | event_kind out_port out_pin level error last    | valid/ready
//
// Start/stop: the request is dequeued, then entries are scanned in order up to
// the match or the end. Tick: all allocated entries are walked in order through
// the single table read port, holding while a drive word waits on the result.
// Reset clears the allocated count and control state; table contents stay
// undefined and need no clearing pass. The two-entry request queue keeps
// accepting, until full, while the sequencer waits on a full result register.
`default_nettype none

module multi_channel_software_pwm #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  mcsp_in_if.sink     in_ch,
  mcsp_out_if.source  out_ch
);

  logic                q_valid;
  logic                q_pop;
  mcsp_pkg::req_item_t q_item;

  mcsp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  mcsp_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
